// ----- rtl/core/cmdpv_pkg.sv -----
// ----------------------------------------------------------------------------
// Command line parser package
// Shared types and constants for the character-serial command line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cmdpv_pkg;

   typedef enum logic [5:0] {
      PH_START  = 6'b000001,
      PH_CODE   = 6'b000010,
      PH_SKIP   = 6'b000100,
      PH_GAP    = 6'b001000,
      PH_SIGN   = 6'b010000,
      PH_DIGITS = 6'b100000
   } phase_type;

   localparam logic [1:0] WORD_OTHER   = 2'd0;
   localparam logic [1:0] WORD_MACHINE = 2'd1;
   localparam logic [1:0] WORD_MOTION  = 2'd2;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_MISSING_P = 2'd1;
   localparam logic [1:0] ERR_MISSING_I = 2'd2;

   localparam logic [3:0] MACHINE_UNKNOWN = 4'd15;
   localparam logic [3:0] MACHINE_M99     = 4'd14;
   localparam logic [3:0] MACHINE_M10     = 4'd8;
   localparam logic [3:0] MACHINE_M11     = 4'd9;
   localparam logic [3:0] MACHINE_M12     = 4'd10;
   localparam logic [3:0] MACHINE_M14     = 4'd12;
   localparam logic [3:0] MACHINE_M15     = 4'd13;
   localparam logic [1:0] MOTION_UNKNOWN  = 2'd2;

   localparam logic [9:0] CODE_MAX = 10'd1023;
   localparam logic [9:0] CODE_99  = 10'd99;

   localparam logic [7:0] CHAR_M     = 8'h4D;
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_I     = 8'h49;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_GAP   = 8'h20;

   typedef struct packed {
      logic [1:0] word_kind;
      logic [9:0] code;
      logic       code_seen;
      logic       has_i;
      logic       has_p;
   } summary_type;

   typedef struct packed {
      logic [3:0] machine_code;
      logic [1:0] motion_code;
      logic       is_valid;
      logic [1:0] error_kind;
   } verdict_type;

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         r = c - CASE_GAP;
      end
      return r;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cmdpv_validate.sv -----
// ----------------------------------------------------------------------------
// Command validation
// Maps the parsed word and code to command indexes and checks that the
// parameters each command requires are present.
// ----------------------------------------------------------------------------
`default_nettype none

module cmdpv_validate (
   input  wire cmdpv_pkg::summary_type summary,
   output cmdpv_pkg::verdict_type      verdict
);

   logic [3:0] machine_idx;
   logic [1:0] motion_idx;
   logic       needs_i;

   always_comb begin
      machine_idx = cmdpv_pkg::MACHINE_UNKNOWN;
      if (summary.code_seen) begin
         if (summary.code <= 10'd1) begin
            machine_idx = summary.code[3:0];
         end else if (summary.code >= 10'd4 && summary.code <= 10'd15) begin
            machine_idx = summary.code[3:0] - 4'd2;
         end else if (summary.code == cmdpv_pkg::CODE_99) begin
            machine_idx = cmdpv_pkg::MACHINE_M99;
         end
      end

      motion_idx = cmdpv_pkg::MOTION_UNKNOWN;
      if (summary.code_seen && summary.code <= 10'd1) begin
         motion_idx = {1'b0, summary.code[0]};
      end

      needs_i = (machine_idx == cmdpv_pkg::MACHINE_M10) ||
                (machine_idx == cmdpv_pkg::MACHINE_M11) ||
                (machine_idx == cmdpv_pkg::MACHINE_M12) ||
                (machine_idx == cmdpv_pkg::MACHINE_M14) ||
                (machine_idx == cmdpv_pkg::MACHINE_M15);

      verdict.machine_code = cmdpv_pkg::MACHINE_UNKNOWN;
      verdict.motion_code  = cmdpv_pkg::MOTION_UNKNOWN;
      verdict.is_valid     = 1'b1;
      verdict.error_kind   = cmdpv_pkg::ERR_NONE;

      unique case (summary.word_kind)
         cmdpv_pkg::WORD_MACHINE: begin
            verdict.machine_code = machine_idx;
            if (needs_i && !summary.has_i) begin
               verdict.is_valid   = 1'b0;
               verdict.error_kind = cmdpv_pkg::ERR_MISSING_I;
            end
         end
         cmdpv_pkg::WORD_MOTION: begin
            verdict.motion_code = motion_idx;
            if (motion_idx != cmdpv_pkg::MOTION_UNKNOWN && !summary.has_p) begin
               verdict.is_valid   = 1'b0;
               verdict.error_kind = cmdpv_pkg::ERR_MISSING_P;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/command_line_parse_validate.sv -----
// ----------------------------------------------------------------------------
// Command line parser and validator
// Parses a G-code style command line one character per transaction and
// returns one validated command summary after the last character.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Ports                         Moves
//   req       in          req_valid, req_stall, req_*   one character, last flag
//   rsp       out         rsp_valid, rsp_stall, rsp_*   one parsed command
//
// One character is accepted per cycle unless a stalled result holds a last
// character in the input register. A character lands in the input register,
// the parse state is updated from it when it advances out of that register,
// and on the last character the result register is loaded at that same edge.
// Reset is synchronous and returns the parser to the start of a command. A
// stalled result blocks only a last character; other characters keep flowing.

`default_nettype none

module command_line_parse_validate #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_char_code,
   input  wire logic               req_last_char,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_word_kind,
   output logic [3:0]              rsp_machine_code,
   output logic [1:0]              rsp_motion_code,
   output logic signed [31:0]      rsp_i_value,
   output logic                    rsp_has_i,
   output logic signed [31:0]      rsp_p_value,
   output logic                    rsp_has_p,
   output logic                    rsp_is_valid,
   output logic [1:0]              rsp_error_kind
);

   localparam int PROD_BITS = VALUE_BITS + 4;
   localparam logic [VALUE_BITS-1:0] VALUE_LIMIT = {1'b0, {(VALUE_BITS-1){1'b1}}};

   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [7:0]                  in_char_ff;
   logic                        in_last_ff;

   cmdpv_pkg::phase_type        phase_ff, phase_in;
   logic [1:0]                  kind_ff, kind_in;
   logic [9:0]                  code_ff, code_in;
   logic                        seen_ff, seen_in;
   logic [7:0]                  letter_ff, letter_in;
   logic                        neg_ff, neg_in;
   logic [VALUE_BITS-1:0]       acc_ff, acc_in;
   logic signed [VALUE_BITS-1:0] i_reg_ff, i_reg_in;
   logic                        i_pres_ff, i_pres_in;
   logic signed [VALUE_BITS-1:0] p_reg_ff, p_reg_in;
   logic                        p_pres_ff, p_pres_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  word_kind_ff;
   cmdpv_pkg::verdict_type      verdict_ff;
   logic signed [31:0]          i_value_ff;
   logic                        has_i_ff;
   logic signed [31:0]          p_value_ff;
   logic                        has_p_ff;

   logic                        out_free;
   logic                        advance;
   logic [7:0]                  upper;
   logic                        digit;
   logic [3:0]                  digit_val;
   logic [13:0]                 code_prod;
   logic [9:0]                  code_next;
   logic [PROD_BITS-1:0]        val_prod;
   logic [VALUE_BITS-1:0]       val_next;
   logic signed [VALUE_BITS-1:0] commit_val;
   logic signed [VALUE_BITS-1:0] fin_val;
   logic                        do_commit;
   logic                        do_gap;
   logic signed [VALUE_BITS-1:0] fin_i, fin_p;
   logic                        fin_i_pres, fin_p_pres;
   cmdpv_pkg::summary_type      summary;
   cmdpv_pkg::verdict_type      verdict;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   assign upper     = cmdpv_pkg::fold_upper(in_char_ff);
   assign digit     = cmdpv_pkg::is_digit(in_char_ff);
   assign digit_val = 4'(in_char_ff - cmdpv_pkg::CHAR_ZERO);

   assign code_prod  = {1'b0, code_ff, 3'b000} + {3'b000, code_ff, 1'b0} + {10'd0, digit_val};
   assign code_next  = (code_prod > {4'd0, cmdpv_pkg::CODE_MAX}) ?
                       cmdpv_pkg::CODE_MAX : code_prod[9:0];
   assign val_prod   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                       + PROD_BITS'(digit_val);
   assign val_next   = (val_prod > PROD_BITS'(VALUE_LIMIT)) ?
                       VALUE_LIMIT : val_prod[VALUE_BITS-1:0];
   assign commit_val = neg_ff ? $signed(-acc_ff) : $signed(acc_ff);
   assign fin_val    = neg_in ? $signed(-acc_in) : $signed(acc_in);

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      code_in   = code_ff;
      seen_in   = seen_ff;
      letter_in = letter_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      i_reg_in  = i_reg_ff;
      i_pres_in = i_pres_ff;
      p_reg_in  = p_reg_ff;
      p_pres_in = p_pres_ff;
      do_commit = 1'b0;
      do_gap    = 1'b0;

      unique case (phase_ff)
         cmdpv_pkg::PH_START: begin
            if (upper == cmdpv_pkg::CHAR_M) begin
               kind_in  = cmdpv_pkg::WORD_MACHINE;
               phase_in = cmdpv_pkg::PH_CODE;
            end else if (upper == cmdpv_pkg::CHAR_G) begin
               kind_in  = cmdpv_pkg::WORD_MOTION;
               phase_in = cmdpv_pkg::PH_CODE;
            end else begin
               kind_in  = cmdpv_pkg::WORD_OTHER;
               phase_in = cmdpv_pkg::PH_SKIP;
            end
         end
         cmdpv_pkg::PH_CODE: begin
            if (digit) begin
               code_in = code_next;
               seen_in = 1'b1;
            end else begin
               do_gap = 1'b1;
            end
         end
         cmdpv_pkg::PH_GAP: begin
            do_gap = 1'b1;
         end
         cmdpv_pkg::PH_SIGN: begin
            if (in_char_ff == cmdpv_pkg::CHAR_MINUS) begin
               neg_in   = 1'b1;
               phase_in = cmdpv_pkg::PH_DIGITS;
            end else if (digit) begin
               acc_in   = val_next;
               phase_in = cmdpv_pkg::PH_DIGITS;
            end else begin
               do_commit = 1'b1;
               do_gap    = 1'b1;
            end
         end
         cmdpv_pkg::PH_DIGITS: begin
            if (digit) begin
               acc_in = val_next;
            end else begin
               do_commit = 1'b1;
               do_gap    = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (do_commit) begin
         if (letter_ff == cmdpv_pkg::CHAR_I) begin
            i_reg_in  = commit_val;
            i_pres_in = 1'b1;
         end else if (letter_ff == cmdpv_pkg::CHAR_P) begin
            p_reg_in  = commit_val;
            p_pres_in = 1'b1;
         end
      end

      if (do_gap) begin
         if (in_char_ff == cmdpv_pkg::CHAR_SPACE) begin
            phase_in = cmdpv_pkg::PH_GAP;
         end else begin
            letter_in = upper;
            neg_in    = 1'b0;
            acc_in    = '0;
            phase_in  = cmdpv_pkg::PH_SIGN;
         end
      end
   end

   // A parameter still open at the end of the line is committed here.
   always_comb begin
      fin_i      = i_reg_in;
      fin_i_pres = i_pres_in;
      fin_p      = p_reg_in;
      fin_p_pres = p_pres_in;
      if (phase_in == cmdpv_pkg::PH_SIGN || phase_in == cmdpv_pkg::PH_DIGITS) begin
         if (letter_in == cmdpv_pkg::CHAR_I) begin
            fin_i      = fin_val;
            fin_i_pres = 1'b1;
         end else if (letter_in == cmdpv_pkg::CHAR_P) begin
            fin_p      = fin_val;
            fin_p_pres = 1'b1;
         end
      end
      summary.word_kind = kind_in;
      summary.code      = code_in;
      summary.code_seen = seen_in;
      summary.has_i     = fin_i_pres;
      summary.has_p     = fin_p_pres;
   end

   cmdpv_validate u_validate (
      .summary (summary),
      .verdict (verdict)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && in_last_ff)) begin
         phase_ff  <= cmdpv_pkg::PH_START;
         kind_ff   <= cmdpv_pkg::WORD_OTHER;
         code_ff   <= '0;
         seen_ff   <= 1'b0;
         letter_ff <= '0;
         neg_ff    <= 1'b0;
         acc_ff    <= '0;
         i_reg_ff  <= '0;
         i_pres_ff <= 1'b0;
         p_reg_ff  <= '0;
         p_pres_ff <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         code_ff   <= code_in;
         seen_ff   <= seen_in;
         letter_ff <= letter_in;
         neg_ff    <= neg_in;
         acc_ff    <= acc_in;
         i_reg_ff  <= i_reg_in;
         i_pres_ff <= i_pres_in;
         p_reg_ff  <= p_reg_in;
         p_pres_ff <= p_pres_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         word_kind_ff <= kind_in;
         verdict_ff   <= verdict;
         i_value_ff   <= 32'(fin_i);
         has_i_ff     <= fin_i_pres;
         p_value_ff   <= 32'(fin_p);
         has_p_ff     <= fin_p_pres;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_word_kind    = word_kind_ff;
   assign rsp_machine_code = verdict_ff.machine_code;
   assign rsp_motion_code  = verdict_ff.motion_code;
   assign rsp_i_value      = i_value_ff;
   assign rsp_has_i        = has_i_ff;
   assign rsp_p_value      = p_value_ff;
   assign rsp_has_p        = has_p_ff;
   assign rsp_is_valid     = verdict_ff.is_valid;
   assign rsp_error_kind   = verdict_ff.error_kind;

endmodule

`default_nettype wire

// ----- tb/sv/tb_command_line_parse_validate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line parser and validator testbench
// Sends command lines one character per transaction. A predictor in this
// module tracks the parse of every accepted character. On each last
// character it queues the expected command summary. A separate process takes
// results under random stall and compares every field with the oldest queued
// summary. The stimulus has directed lines, a long result hold-off, drain
// pauses and well-formed random lines mixed with noise.
// ----------------------------------------------------------------------------

module tb_command_line_parse_validate;

   localparam int VALUE_BITS = 32;
   localparam longint unsigned VALUE_LIMIT = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
   localparam int PERIOD = 20;
   localparam int MAX_WAIT = 16;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RESULT_LATENCY = 2;
   localparam int RANDOM_CHARS = 1430;
   localparam int MAX_REPORTS = 40;
   localparam logic [7:0] CHAR_UP_A = 8'h41;
   localparam logic [7:0] CHAR_UP_Z = 8'h5A;
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_TOP = 8'hFF;

   typedef logic [7:0] char_seq_type[$];

   typedef struct packed {
      logic [1:0]  word_kind;
      logic [3:0]  machine_code;
      logic [1:0]  motion_code;
      logic [31:0] i_value;
      logic        has_i;
      logic [31:0] p_value;
      logic        has_p;
      logic        is_valid;
      logic [1:0]  error_kind;
   } command_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_char_code = 8'd0;
   logic               req_last_char = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic [1:0]         rsp_word_kind;
   logic [3:0]         rsp_machine_code;
   logic [1:0]         rsp_motion_code;
   logic signed [31:0] rsp_i_value;
   logic               rsp_has_i;
   logic signed [31:0] rsp_p_value;
   logic               rsp_has_p;
   logic               rsp_is_valid;
   logic [1:0]         rsp_error_kind;

   logic               hold_request = 1'b0;
   int                 sink_hold;
   int                 sink_wait;
   int                 sink_draw;
   bit                 sink_idle_on = 1'b1;
   bit                 sender_idle_on = 1'b1;

   int                 mismatch_count;
   int                 results_checked;
   int                 chars_sent;
   int                 lines_sent;

   command_result_type expected_commands[$];

   cmdpv_pkg::phase_type line_phase = cmdpv_pkg::PH_START;
   logic [1:0]         line_word;
   int unsigned        line_code;
   logic               line_code_seen;
   logic [7:0]         line_letter;
   logic               line_negative;
   longint unsigned    line_magnitude;
   logic [31:0]        line_i;
   logic               line_has_i;
   logic [31:0]        line_p;
   logic               line_has_p;

   command_line_parse_validate #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .req_last_char(req_last_char),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word_kind(rsp_word_kind),
      .rsp_machine_code(rsp_machine_code),
      .rsp_motion_code(rsp_motion_code),
      .rsp_i_value(rsp_i_value),
      .rsp_has_i(rsp_has_i),
      .rsp_p_value(rsp_p_value),
      .rsp_has_p(rsp_has_p),
      .rsp_is_valid(rsp_is_valid),
      .rsp_error_kind(rsp_error_kind)
   );

   always #(PERIOD / 2) clock = ~clock;

   initial begin
      #(20_000_000);
      $display("command_line_parse_validate regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Parse predictor
   // ------------------------------------------------------------------

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c inside {[cmdpv_pkg::CHAR_LOW_A:cmdpv_pkg::CHAR_LOW_Z]}) ?
             c - cmdpv_pkg::CASE_GAP : c;
   endfunction

   function automatic logic decimal_char(input logic [7:0] c);
      return c inside {[cmdpv_pkg::CHAR_ZERO:cmdpv_pkg::CHAR_NINE]};
   endfunction

   function automatic void clear_line_state();
      line_phase = cmdpv_pkg::PH_START;
      line_word = cmdpv_pkg::WORD_OTHER;
      line_code = 0;
      line_code_seen = 1'b0;
      line_letter = 8'd0;
      line_negative = 1'b0;
      line_magnitude = 0;
      line_i = 32'd0;
      line_has_i = 1'b0;
      line_p = 32'd0;
      line_has_p = 1'b0;
   endfunction

   function automatic void add_value_digit(input logic [7:0] c);
      longint unsigned d;
      d = 64'(c - cmdpv_pkg::CHAR_ZERO);
      if (line_magnitude > (VALUE_LIMIT - d) / 10) begin
         line_magnitude = VALUE_LIMIT;
      end else begin
         line_magnitude = line_magnitude * 10 + d;
      end
   endfunction

   function automatic void add_code_digit(input logic [7:0] c);
      int unsigned d;
      d = 32'(c - cmdpv_pkg::CHAR_ZERO);
      if (line_code > (cmdpv_pkg::CODE_MAX - d) / 10) begin
         line_code = cmdpv_pkg::CODE_MAX;
      end else begin
         line_code = line_code * 10 + d;
      end
      line_code_seen = 1'b1;
   endfunction

   function automatic void commit_parameter();
      logic [63:0] v;
      v = line_negative ? 64'd0 - line_magnitude : line_magnitude;
      if (line_letter == cmdpv_pkg::CHAR_I) begin
         line_i = v[31:0];
         line_has_i = 1'b1;
      end else if (line_letter == cmdpv_pkg::CHAR_P) begin
         line_p = v[31:0];
         line_has_p = 1'b1;
      end
   endfunction

   function automatic void open_parameter(input logic [7:0] c);
      line_phase = cmdpv_pkg::PH_GAP;
      if (c != cmdpv_pkg::CHAR_SPACE) begin
         line_letter = to_upper(c);
         line_negative = 1'b0;
         line_magnitude = 0;
         line_phase = cmdpv_pkg::PH_SIGN;
      end
   endfunction

   function automatic void close_line();
      command_result_type r;
      if (line_phase == cmdpv_pkg::PH_SIGN || line_phase == cmdpv_pkg::PH_DIGITS) begin
         commit_parameter();
      end
      r.word_kind = line_word;
      r.machine_code = cmdpv_pkg::MACHINE_UNKNOWN;
      r.motion_code = cmdpv_pkg::MOTION_UNKNOWN;
      r.i_value = line_i;
      r.has_i = line_has_i;
      r.p_value = line_p;
      r.has_p = line_has_p;
      r.is_valid = 1'b1;
      r.error_kind = cmdpv_pkg::ERR_NONE;
      if (line_word == cmdpv_pkg::WORD_MACHINE) begin
         if (line_code_seen) begin
            if (line_code <= 1) begin
               r.machine_code = 4'(line_code);
            end else if (line_code >= 4 && line_code <= 15) begin
               r.machine_code = 4'(line_code - 2);
            end else if (line_code == cmdpv_pkg::CODE_99) begin
               r.machine_code = cmdpv_pkg::MACHINE_M99;
            end
         end
         if (r.machine_code inside {cmdpv_pkg::MACHINE_M10, cmdpv_pkg::MACHINE_M11,
                                    cmdpv_pkg::MACHINE_M12, cmdpv_pkg::MACHINE_M14,
                                    cmdpv_pkg::MACHINE_M15} && !line_has_i) begin
            r.is_valid = 1'b0;
            r.error_kind = cmdpv_pkg::ERR_MISSING_I;
         end
      end else if (line_word == cmdpv_pkg::WORD_MOTION) begin
         if (line_code_seen && line_code <= 1) begin
            r.motion_code = 2'(line_code);
         end
         if (r.motion_code != cmdpv_pkg::MOTION_UNKNOWN && !line_has_p) begin
            r.is_valid = 1'b0;
            r.error_kind = cmdpv_pkg::ERR_MISSING_P;
         end
      end
      expected_commands.push_back(r);
      clear_line_state();
   endfunction

   function automatic void parse_character(input logic [7:0] c, input logic last);
      case (line_phase)
         cmdpv_pkg::PH_START: begin
            if (to_upper(c) == cmdpv_pkg::CHAR_M) begin
               line_word = cmdpv_pkg::WORD_MACHINE;
               line_phase = cmdpv_pkg::PH_CODE;
            end else if (to_upper(c) == cmdpv_pkg::CHAR_G) begin
               line_word = cmdpv_pkg::WORD_MOTION;
               line_phase = cmdpv_pkg::PH_CODE;
            end else begin
               line_word = cmdpv_pkg::WORD_OTHER;
               line_phase = cmdpv_pkg::PH_SKIP;
            end
         end
         cmdpv_pkg::PH_CODE: begin
            if (decimal_char(c)) begin
               add_code_digit(c);
            end else begin
               open_parameter(c);
            end
         end
         cmdpv_pkg::PH_GAP: begin
            open_parameter(c);
         end
         cmdpv_pkg::PH_SIGN: begin
            if (c == cmdpv_pkg::CHAR_MINUS) begin
               line_negative = 1'b1;
               line_phase = cmdpv_pkg::PH_DIGITS;
            end else if (decimal_char(c)) begin
               add_value_digit(c);
               line_phase = cmdpv_pkg::PH_DIGITS;
            end else begin
               commit_parameter();
               open_parameter(c);
            end
         end
         cmdpv_pkg::PH_DIGITS: begin
            if (decimal_char(c)) begin
               add_value_digit(c);
            end else begin
               commit_parameter();
               open_parameter(c);
            end
         end
         default: begin
         end
      endcase
      if (last) begin
         close_line();
      end
   endfunction

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("MISMATCH at %0t: %s got %0h expected %0h (result %0d)",
                  $time, what, got, want, results_checked);
      end
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   task automatic check_command();
      command_result_type want;
      results_checked++;
      if (expected_commands.size() == 0) begin
         report_mismatch("result with no command pending", 32'd0, 32'd0);
         return;
      end
      want = expected_commands.pop_front();
      compare_field("word_kind", 32'(rsp_word_kind), 32'(want.word_kind));
      compare_field("machine_code", 32'(rsp_machine_code), 32'(want.machine_code));
      compare_field("motion_code", 32'(rsp_motion_code), 32'(want.motion_code));
      compare_field("i_value", rsp_i_value, want.i_value);
      compare_field("has_i", 32'(rsp_has_i), 32'(want.has_i));
      compare_field("p_value", rsp_p_value, want.p_value);
      compare_field("has_p", 32'(rsp_has_p), 32'(want.has_p));
      compare_field("is_valid", 32'(rsp_is_valid), 32'(want.is_valid));
      compare_field("error_kind", 32'(rsp_error_kind), 32'(want.error_kind));
   endtask

   function automatic int draw_wait(input bit enabled);
      return enabled ? int'($urandom_range(0, MAX_WAIT)) : 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
         sink_wait <= 0;
         sink_hold <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_command();
         end
         if (hold_request) begin
            sink_hold <= LONG_HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            sink_draw = draw_wait(sink_idle_on);
            sink_wait <= sink_draw;
            rsp_stall <= (sink_draw != 0);
         end else if (sink_wait > 1) begin
            sink_wait <= sink_wait - 1;
            rsp_stall <= 1'b1;
         end else begin
            sink_wait <= 0;
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      gap = draw_wait(sender_idle_on);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_last_char <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_character(c, last);
      chars_sent++;
   endtask

   task automatic send_line(input char_seq_type s);
      foreach (s[j]) begin
         send_char(s[j], j == s.size() - 1);
      end
      lines_sent++;
   endtask

   task automatic send_text(input string t);
      char_seq_type s;
      foreach (t[j]) begin
         s.push_back(t[j]);
      end
      send_line(s);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_commands.size() != 0);
   endtask

   function automatic int unsigned known_code();
      int unsigned k;
      k = $urandom_range(0, 14);
      return (k <= 1) ? k : (k == 14) ? 99 : k + 2;
   endfunction

   function automatic char_seq_type random_line();
      char_seq_type s;
      string digits;
      logic [7:0] c;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(0, 255)));
         return s;
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: s.push_back(cmdpv_pkg::CHAR_M);
         4, 5, 6:    s.push_back(cmdpv_pkg::CHAR_G);
         7:          s.push_back(($urandom_range(0, 1) ? cmdpv_pkg::CHAR_M : cmdpv_pkg::CHAR_G)
                                 + cmdpv_pkg::CASE_GAP);
         default:    s.push_back(8'($urandom_range(0, 255)));
      endcase
      case ($urandom_range(0, 7))
         0, 1, 2: digits = $sformatf("%0d", known_code());
         3, 4:    digits = $sformatf("%0d", $urandom_range(0, 120));
         5:       digits = $sformatf("%0d", $urandom_range(1000, 999999));
         6:       digits = {"0", $sformatf("%0d", $urandom_range(0, 15))};
         default: digits = "";
      endcase
      foreach (digits[j]) begin
         s.push_back(digits[j]);
      end
      repeat ($urandom_range(0, 4)) begin
         repeat ($urandom_range(0, 2)) s.push_back(cmdpv_pkg::CHAR_SPACE);
         case ($urandom_range(0, 9))
            0, 1, 2: c = cmdpv_pkg::CHAR_I;
            3, 4, 5: c = cmdpv_pkg::CHAR_P;
            6:       c = ($urandom_range(0, 1) ? cmdpv_pkg::CHAR_I : cmdpv_pkg::CHAR_P)
                         + cmdpv_pkg::CASE_GAP;
            7:       c = 8'($urandom_range(CHAR_UP_A, CHAR_UP_Z));
            default: c = 8'($urandom_range(0, 255));
         endcase
         s.push_back(c);
         if ($urandom_range(0, 3) == 0) begin
            s.push_back(cmdpv_pkg::CHAR_MINUS);
         end
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 4)) begin
            s.push_back(8'(cmdpv_pkg::CHAR_ZERO + $urandom_range(0, 9)));
         end
      end
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   task automatic test_directed_lines();
      sender_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      send_text("M10");
      send_text("m11 i-7");
      send_text("M12 I9999999999");
      send_text("G0 P5");
      send_text("g1");
      send_text("G");
      send_text("M99 p-");
      send_text("X1 P5");
      send_text("M5000 I1");
      send_text("M14I3P");
      send_text("G1 P-4-2 Q");
      send_text("M15 I1 I-2");
      send_line('{cmdpv_pkg::CHAR_G, cmdpv_pkg::CHAR_ZERO + 8'd1, CHAR_NUL,
                  cmdpv_pkg::CHAR_P, CHAR_TOP, cmdpv_pkg::CHAR_NINE});
      send_text("M");
      wait_for_drain();
   endtask

   task automatic test_result_backpressure();
      sender_idle_on = 1'b0;
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      repeat (12) send_line(random_line());
      wait_for_drain();
   endtask

   task automatic test_drain_pauses();
      sender_idle_on = 1'b1;
      sink_idle_on = 1'b1;
      repeat (6) begin
         send_line(random_line());
         wait_for_drain();
      end
   endtask

   task automatic test_random_lines();
      int start_chars;
      start_chars = chars_sent;
      while (chars_sent - start_chars < RANDOM_CHARS) begin
         if (lines_sent % 16 == 0) begin
            sender_idle_on = $urandom_range(0, 2) != 0;
            sink_idle_on = $urandom_range(0, 2) != 0;
         end
         send_line(random_line());
      end
      wait_for_drain();
   endtask

   initial begin
      clear_line_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_lines();
      test_result_backpressure();
      test_drain_pauses();
      test_random_lines();
      sink_idle_on = 1'b0;
      wait_for_drain();
      repeat (RESULT_LATENCY + 10) @(posedge clock);
      $display("Sent %0d characters in %0d command lines and checked %0d results.",
               chars_sent, lines_sent, results_checked);
      $display("Lines covered M, G and unknown words, missing parameters and saturation.");
      if (mismatch_count == 0 && expected_commands.size() == 0) begin
         $display("command_line_parse_validate regression: pass");
      end else begin
         $display("command_line_parse_validate regression: fail");
      end
      $finish;
   end

endmodule
